### rtl/core/evsm_pkg.sv
// Shared types and constants for the eight-voice sample mixer.
package evsm_pkg;

    // Sample store geometry
    localparam int SAMPLE_DEPTH = 16384;
    localparam int SAMPLE_AW    = 14;

    // Stream widths
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int COUNT_W    = 4;

    // Saturation limits of the 8-bit mix
    localparam logic signed [7:0] MIX_MAX = 8'sd127;
    localparam logic signed [7:0] MIX_MIN = -8'sd128;

    // Action codes carried on s_tuser
    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_PLAY  = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_QUERY = 3'd3,
        ACT_MIX   = 3'd4
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_SAMPLE,
        ST_DONE
    } state_t;

    // One input item
    typedef struct packed {
        logic [2:0]           action;
        logic [SAMPLE_AW-1:0] address;
        logic signed [7:0]    sample_in;
        logic [5:0]           scale;
        logic [14:0]          length;
        logic [15:0]          label;
        logic                 loop_flag;
    } item_t;

    // One result item
    typedef struct packed {
        logic signed [7:0]    mixed_sample;
        logic                 accepted;
        logic                 playing;
        logic [COUNT_W-1:0]   active_count;
    } result_t;

    // One voice table entry as held in the voice memory
    typedef struct packed {
        logic [15:0]          label;
        logic [SAMPLE_AW-1:0] base;
        logic [14:0]          length;
        logic [14:0]          cursor;
        logic                 loop_flag;
    } voice_t;

endpackage

### rtl/core/evsm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module evsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register every read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/evsm_ctrl.sv
// Action sequencer: voice busy flags, count, and read-modify-write of the voice memory.
module evsm_ctrl #(
    parameter int VOICES = 8,
    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  evsm_pkg::item_t                 item,
    input  logic                            sound_enabled,
    input  logic                            out_free,
    output logic                            res_done,
    output evsm_pkg::result_t               result,
    output logic                            vram_we,
    output logic [VIW-1:0]                  vram_waddr,
    output evsm_pkg::voice_t                vram_wdata,
    output logic [VIW-1:0]                  vram_raddr,
    input  evsm_pkg::voice_t                vram_rdata,
    output logic                            sram_we,
    output logic [evsm_pkg::SAMPLE_AW-1:0]  sram_waddr,
    output logic [7:0]                      sram_wdata,
    output logic [evsm_pkg::SAMPLE_AW-1:0]  sram_raddr,
    input  logic [7:0]                      sram_rdata
);

    localparam int CW = $clog2(VOICES + 1);

    evsm_pkg::state_t  state_reg, state_next;
    evsm_pkg::item_t   item_reg, item_next;
    logic [VIW-1:0]    vidx_reg, vidx_next;
    logic signed [7:0] acc_reg, acc_next;
    logic [VOICES-1:0] busy_reg, busy_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              accepted_reg, accepted_next;
    logic              playing_reg, playing_next;

    logic              free_found;
    logic [VIW-1:0]    free_idx;
    logic              last_voice;
    logic              label_hit;
    logic              cur_wrap;
    logic              drop_voice;
    logic [14:0]       cur_eff;
    logic signed [14:0] scaled;
    logic signed [8:0] sum9;
    logic [CW+3:0]     count_ext;

    // Find the lowest free voice
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = VIW'(i);
            end
        end
    end

    // Voice entry decode and datapath helpers
    assign last_voice = (vidx_reg == VIW'(VOICES - 1));
    assign label_hit  = (vram_rdata.label == item_reg.label);
    assign cur_wrap   = (vram_rdata.cursor >= vram_rdata.length);
    assign drop_voice = cur_wrap && (!vram_rdata.loop_flag || (vram_rdata.length == '0));
    assign cur_eff    = cur_wrap ? '0 : vram_rdata.cursor;
    assign scaled     = item_reg.sample_in * $signed({1'b0, item_reg.scale});
    assign sum9       = {acc_reg[7], acc_reg} + {sram_rdata[7], sram_rdata};
    assign count_ext  = {4'b0, count_reg};

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= evsm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= '0;
            count_reg    <= '0;
            vidx_reg     <= '0;
            acc_reg      <= '0;
            accepted_reg <= 1'b0;
            playing_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            vidx_reg     <= vidx_next;
            acc_reg      <= acc_next;
            accepted_reg <= accepted_next;
            playing_reg  <= playing_next;
        end
        item_reg <= item_next;
    end

    // Next state, memory accesses and result
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        vidx_next     = vidx_reg;
        acc_next      = acc_reg;
        busy_next     = busy_reg;
        count_next    = count_reg;
        accepted_next = accepted_reg;
        playing_next  = playing_reg;
        item_ready    = 1'b0;
        res_done      = 1'b0;
        vram_we       = 1'b0;
        vram_waddr    = vidx_reg;
        vram_wdata    = vram_rdata;
        vram_raddr    = vidx_reg;
        sram_we       = 1'b0;
        sram_waddr    = item_reg.address;
        sram_wdata    = scaled[12:5];
        sram_raddr    = vram_rdata.base + cur_eff[evsm_pkg::SAMPLE_AW-1:0];

        unique case (state_reg)
            evsm_pkg::ST_IDLE: begin
                // Take an item and clear the per-item results
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next     = item;
                    vidx_next     = '0;
                    acc_next      = '0;
                    accepted_next = 1'b0;
                    playing_next  = 1'b0;
                    state_next    = evsm_pkg::ST_START;
                end
            end

            evsm_pkg::ST_START: begin
                state_next = evsm_pkg::ST_DONE;
                case (evsm_pkg::action_t'(item_reg.action))
                    evsm_pkg::ACT_WRITE: begin
                        // Store floor(sample * scale / 32), low byte
                        sram_we = 1'b1;
                    end
                    evsm_pkg::ACT_PLAY: begin
                        // Claim the lowest free voice
                        if (sound_enabled && free_found) begin
                            vram_we              = 1'b1;
                            vram_waddr           = free_idx;
                            vram_wdata.label     = item_reg.label;
                            vram_wdata.base      = item_reg.address;
                            vram_wdata.length    = item_reg.length;
                            vram_wdata.cursor    = '0;
                            vram_wdata.loop_flag = item_reg.loop_flag;
                            busy_next[free_idx]  = 1'b1;
                            count_next           = count_reg + CW'(1);
                            accepted_next        = 1'b1;
                        end
                    end
                    evsm_pkg::ACT_STOP,
                    evsm_pkg::ACT_QUERY,
                    evsm_pkg::ACT_MIX: begin
                        state_next = evsm_pkg::ST_READ;
                    end
                    default: begin
                        state_next = evsm_pkg::ST_DONE;
                    end
                endcase
            end

            evsm_pkg::ST_READ: begin
                // Read busy voices, skip free ones
                if (busy_reg[vidx_reg]) begin
                    state_next = evsm_pkg::ST_EVAL;
                end else if (last_voice) begin
                    state_next = evsm_pkg::ST_DONE;
                end else begin
                    vidx_next = vidx_reg + VIW'(1);
                end
            end

            evsm_pkg::ST_EVAL: begin
                // Voice entry is on the memory output
                if (last_voice) begin
                    state_next = evsm_pkg::ST_DONE;
                end else begin
                    state_next = evsm_pkg::ST_READ;
                    vidx_next  = vidx_reg + VIW'(1);
                end
                case (evsm_pkg::action_t'(item_reg.action))
                    evsm_pkg::ACT_STOP: begin
                        if (label_hit) begin
                            busy_next[vidx_reg] = 1'b0;
                            count_next          = count_reg - CW'(1);
                        end
                    end
                    evsm_pkg::ACT_QUERY: begin
                        if (label_hit) begin
                            playing_next = 1'b1;
                        end
                    end
                    evsm_pkg::ACT_MIX: begin
                        if (drop_voice) begin
                            busy_next[vidx_reg] = 1'b0;
                            count_next          = count_reg - CW'(1);
                        end else begin
                            // Fetch the sample, write back the advanced cursor
                            vram_we           = 1'b1;
                            vram_wdata.cursor = cur_eff + 15'd1;
                            state_next        = evsm_pkg::ST_SAMPLE;
                            vidx_next         = vidx_reg;
                        end
                    end
                    default: begin
                        state_next = evsm_pkg::ST_DONE;
                    end
                endcase
            end

            evsm_pkg::ST_SAMPLE: begin
                // Add with saturation, then move to the next voice
                if (sum9[8] != sum9[7]) begin
                    acc_next = sum9[8] ? evsm_pkg::MIX_MIN : evsm_pkg::MIX_MAX;
                end else begin
                    acc_next = sum9[7:0];
                end
                if (last_voice) begin
                    state_next = evsm_pkg::ST_DONE;
                end else begin
                    state_next = evsm_pkg::ST_READ;
                    vidx_next  = vidx_reg + VIW'(1);
                end
            end

            evsm_pkg::ST_DONE: begin
                // Hand the result over once the output slot is free
                if (out_free) begin
                    res_done   = 1'b1;
                    state_next = evsm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = evsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.mixed_sample = acc_reg;
    assign result.accepted     = accepted_reg;
    assign result.playing      = playing_reg;
    assign result.active_count = count_ext[evsm_pkg::COUNT_W-1:0];

endmodule

### rtl/core/eight_voice_sample_mixer.sv
// Top level of the eight-voice sample mixer: stream ports, memories, output register.
//
// Usage: one item enters on the s_ channel (action on s_tuser, the other fields
// packed in s_tdata) and yields exactly one result on the m_ channel. The
// sound_enabled register is written over the cfg_ channel, which is always ready.
// Items run one at a time through a sequencer that walks the voice memory:
//   write_sample, play and unknown actions never read the voice memory;
//   stop_label and query_label read each voice and evaluate each busy one;
//   mix_frame reads each voice, and for each busy voice that plays on also
//   reads its sample and accumulates it (voice read, sample read, accumulate).
// The walk is paced by the registered reads of the voice and sample memories.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item holds in the sequencer until
// the output register frees up, and no new item is taken meanwhile.
// Reset clears all voices, the busy count and sound_enabled; it needs no clearing
// pass. The sample store holds no defined contents until written.
module eight_voice_sample_mixer #(
    parameter int VOICES = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address[13:0], sample_in[21:14], scale[27:22], length[42:28],
    // label[58:43], loop_flag[59], zero[63:60]
    input  logic [evsm_pkg::S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [evsm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mixed_sample[7:0], accepted[8], playing[9], active_count[13:10], zero[15:14]
    output logic [evsm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);

    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic                          sound_enabled_reg;
    logic                          m_tvalid_reg;
    logic [evsm_pkg::M_TDATA_W-1:0] m_tdata_reg;

    evsm_pkg::item_t               item;
    evsm_pkg::result_t             result;
    logic                          res_done;
    logic                          out_free;

    logic                          vram_we;
    logic [VIW-1:0]                vram_waddr;
    logic [VIW-1:0]                vram_raddr;
    evsm_pkg::voice_t              vram_wdata;
    evsm_pkg::voice_t              vram_rdata;

    logic                          sram_we;
    logic [evsm_pkg::SAMPLE_AW-1:0] sram_waddr;
    logic [evsm_pkg::SAMPLE_AW-1:0] sram_raddr;
    logic [7:0]                    sram_wdata;
    logic [7:0]                    sram_rdata;

    // Unpack the input transfer
    assign item.action    = s_tuser[2:0];
    assign item.address   = s_tdata[13:0];
    assign item.sample_in = s_tdata[21:14];
    assign item.scale     = s_tdata[27:22];
    assign item.length    = s_tdata[42:28];
    assign item.label     = s_tdata[58:43];
    assign item.loop_flag = s_tdata[59];

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_enabled_reg <= 1'b0;
        end else if (cfg_valid) begin
            sound_enabled_reg <= cfg_data;
        end
    end

    evsm_ctrl #(
        .VOICES(VOICES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_tvalid),
        .item_ready    (s_tready),
        .item          (item),
        .sound_enabled (sound_enabled_reg),
        .out_free      (out_free),
        .res_done      (res_done),
        .result        (result),
        .vram_we       (vram_we),
        .vram_waddr    (vram_waddr),
        .vram_wdata    (vram_wdata),
        .vram_raddr    (vram_raddr),
        .vram_rdata    (vram_rdata),
        .sram_we       (sram_we),
        .sram_waddr    (sram_waddr),
        .sram_wdata    (sram_wdata),
        .sram_raddr    (sram_raddr),
        .sram_rdata    (sram_rdata)
    );

    // Voice table memory
    evsm_ram #(
        .WIDTH($bits(evsm_pkg::voice_t)),
        .DEPTH(VOICES)
    ) u_voice_ram (
        .aclk  (aclk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    // Sample store memory
    evsm_ram #(
        .WIDTH(8),
        .DEPTH(evsm_pkg::SAMPLE_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // Output register: load on finish, drop on transfer
    assign out_free = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_done) begin
            m_tdata_reg <= {2'b00, result.active_count, result.playing,
                            result.accepted, result.mixed_sample};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // One item at a time: an accepted item closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A finished item never overwrites a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_done && m_tvalid_reg && !m_tready))
        else $error("result loaded over a stalled result");

    // Play and query flags exclude each other and a mix value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[8] || m_tdata[9])) |->
            (!(m_tdata[8] && m_tdata[9]) && (m_tdata[7:0] == 8'd0)))
        else $error("result flags mixed across actions");
`endif

endmodule

### verif/evsm_mixer_scoreboard.sv
// Scoreboard class for the eight-voice sample mixer: voice and store predictor plus result check.
`timescale 1ns / 100ps

package evsm_mixer_tb_pkg;

    import evsm_pkg::*;

    localparam int NUM_VOICES = 8;
    localparam logic [15:0] FREE_LABEL = 16'hffff;

    class mixer_scoreboard;

        // Predicted block state
        logic [7:0]           store [SAMPLE_DEPTH];
        bit                   written [SAMPLE_DEPTH];
        bit                   busy [NUM_VOICES];
        logic [15:0]          lbl [NUM_VOICES];
        logic [SAMPLE_AW-1:0] base [NUM_VOICES];
        logic [14:0]          len [NUM_VOICES];
        logic [14:0]          cur [NUM_VOICES];
        bit                   looping [NUM_VOICES];
        int unsigned          busy_total;
        bit                   enabled;

        // Expected results in transfer order
        result_t              results_due [$];

        // Bookkeeping for the run summary
        int                   errors;
        int                   items_seen;
        int                   mixes;
        int                   saturations;
        int                   plays_taken;
        int                   plays_refused;
        int                   label_ops;

        function new();
            for (int v = 0; v < NUM_VOICES; v++) begin
                busy[v]    = 1'b0;
                lbl[v]     = FREE_LABEL;
                base[v]    = '0;
                len[v]     = '0;
                cur[v]     = '0;
                looping[v] = 1'b0;
            end
            busy_total = 0;
            enabled    = 1'b0;
            errors     = 0;
        endfunction

        function void set_enabled(bit value);
            enabled = value;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Address the voice reads on the next mix, if it reads at all
        function bit next_read(int v, output logic [SAMPLE_AW-1:0] addr);
            addr = '0;
            if (!busy[v])
                return 1'b0;
            if (cur[v] >= len[v]) begin
                if (!looping[v] || len[v] == 0)
                    return 1'b0;
                addr = base[v];
                return 1'b1;
            end
            addr = base[v] + cur[v][SAMPLE_AW-1:0];
            return 1'b1;
        endfunction

        function void release_voice(int v);
            if (!busy[v])
                return;
            busy[v] = 1'b0;
            lbl[v]  = FREE_LABEL;
            if (busy_total != 0)
                busy_total--;
        endfunction

        // Advance the predicted state by one accepted item and queue its result
        function void note_item(item_t it);
            int                   prod;
            int                   acc;
            bit                   clipped;
            logic [SAMPLE_AW-1:0] addr;
            result_t              res;

            res = '0;
            acc = 0;
            clipped = 1'b0;
            items_seen++;
            case (it.action)
                ACT_WRITE: begin
                    prod = int'($signed(it.sample_in)) * int'(it.scale);
                    prod = prod >>> 5;
                    store[it.address]   = prod[7:0];
                    written[it.address] = 1'b1;
                end
                ACT_PLAY: begin
                    if (enabled) begin
                        for (int v = 0; v < NUM_VOICES; v++) begin
                            if (!busy[v] && !res.accepted) begin
                                busy[v]      = 1'b1;
                                lbl[v]       = it.label;
                                base[v]      = it.address;
                                len[v]       = it.length;
                                cur[v]       = '0;
                                looping[v]   = it.loop_flag;
                                busy_total++;
                                res.accepted = 1'b1;
                            end
                        end
                    end
                    if (res.accepted)
                        plays_taken++;
                    else
                        plays_refused++;
                end
                ACT_STOP: begin
                    label_ops++;
                    for (int v = 0; v < NUM_VOICES; v++)
                        if (busy[v] && lbl[v] == it.label)
                            release_voice(v);
                end
                ACT_QUERY: begin
                    label_ops++;
                    for (int v = 0; v < NUM_VOICES; v++)
                        if (busy[v] && lbl[v] == it.label)
                            res.playing = 1'b1;
                end
                ACT_MIX: begin
                    mixes++;
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (!next_read(v, addr)) begin
                            release_voice(v);
                            continue;
                        end
                        if (cur[v] >= len[v])
                            cur[v] = '0;
                        acc = acc + int'($signed(store[addr]));
                        cur[v] = cur[v] + 15'd1;
                        if (acc > int'(MIX_MAX)) begin
                            acc = int'(MIX_MAX);
                            clipped = 1'b1;
                        end
                        if (acc < int'(MIX_MIN)) begin
                            acc = int'(MIX_MIN);
                            clipped = 1'b1;
                        end
                    end
                    if (clipped)
                        saturations++;
                    res.mixed_sample = acc[7:0];
                end
                default: begin
                end
            endcase
            res.active_count = busy_total[COUNT_W-1:0];
            results_due.push_back(res);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t want;

            if (results_due.size() == 0) begin
                $error("result 0x%04h arrived with no expectation pending", data);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (data[7:0] !== want.mixed_sample) begin
                $error("mixed_sample: expected %0d, actual %0d",
                       $signed(want.mixed_sample), $signed(data[7:0]));
                errors++;
            end
            if (data[8] !== want.accepted) begin
                $error("accepted: expected %0b, actual %0b", want.accepted, data[8]);
                errors++;
            end
            if (data[9] !== want.playing) begin
                $error("playing: expected %0b, actual %0b", want.playing, data[9]);
                errors++;
            end
            if (data[13:10] !== want.active_count) begin
                $error("active_count: expected %0d, actual %0d",
                       want.active_count, data[13:10]);
                errors++;
            end
            if (data[15:14] !== 2'b00) begin
                $error("tdata pad: expected 0, actual %0b", data[15:14]);
                errors++;
            end
        endfunction

    endclass

endpackage

### verif/eight_voice_sample_mixer_test.sv
// Top-level testbench for the eight-voice sample mixer: stimulus, stalls and final verdict.
`timescale 1ns / 100ps

module eight_voice_sample_mixer_test;

    import evsm_pkg::*;
    import evsm_mixer_tb_pkg::*;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          LONG_HOLD     = 300;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 240;
    localparam int          WINDOW_TOP    = 511;
    localparam logic [2:0]  ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;

    mixer_scoreboard        sb = new();
    bit                     quiet;
    bit                     hold_req;
    bit                     tx_calm;
    logic [15:0]            label_pool [6] = '{16'h0000, 16'hffff, 16'h0001,
                                               16'h8000, 16'h1234, 16'h7fff};

    eight_voice_sample_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off on request
    initial begin
        int calm_left;
        bit calm;

        m_tready  <= 1'b0;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            @(posedge aclk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(100, 300);
            end
            calm_left--;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // Drive one item and hold it until the transfer happens
    task automatic send_item(item_t it);
        if (!quiet && !tx_calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {4'b0000, it.loop_flag, it.label, it.length, it.scale,
                     it.sample_in, it.address};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    function automatic item_t random_item(logic [2:0] act);
        item_t it;

        it.action    = act;
        it.address   = SAMPLE_AW'($urandom);
        it.sample_in = 8'($urandom);
        it.scale     = 6'($urandom);
        it.length    = 15'($urandom);
        it.label     = 16'($urandom);
        it.loop_flag = 1'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_label();
        if ($urandom_range(0, 3) != 0)
            return label_pool[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    task automatic do_write(logic [SAMPLE_AW-1:0] addr, logic [7:0] sample, logic [5:0] scale);
        item_t it;

        it           = random_item(ACT_WRITE);
        it.address   = addr;
        it.sample_in = sample;
        it.scale     = scale;
        send_item(it);
    endtask

    task automatic do_play(logic [SAMPLE_AW-1:0] addr, logic [14:0] len,
                           logic [15:0] lbl, logic lp);
        item_t it;

        it           = random_item(ACT_PLAY);
        it.address   = addr;
        it.length    = len;
        it.label     = lbl;
        it.loop_flag = lp;
        send_item(it);
    endtask

    task automatic do_label_op(logic [2:0] act, logic [15:0] lbl);
        item_t it;

        it       = random_item(act);
        it.label = lbl;
        send_item(it);
    endtask

    // Fill any store entry the next mix would read before it was written, then mix
    task automatic do_mix();
        logic [SAMPLE_AW-1:0] addr;

        for (int v = 0; v < NUM_VOICES; v++)
            if (sb.next_read(v, addr) && !sb.written[addr])
                do_write(addr, 8'($urandom), 6'($urandom));
        send_item(random_item(ACT_MIX));
    endtask

    // Hold the sender until every expected result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_enable(bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_enabled(value);
    endtask

    function automatic logic [SAMPLE_AW-1:0] pick_addr();
        if ($urandom_range(0, 9) < 8)
            return SAMPLE_AW'($urandom_range(0, WINDOW_TOP));
        return SAMPLE_AW'($urandom);
    endfunction

    function automatic logic [14:0] pick_length();
        if ($urandom_range(0, 9) < 8)
            return 15'($urandom_range(0, 12));
        return 15'($urandom);
    endfunction

    task automatic random_step();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 30)
            do_mix();
        else if (pick < 50)
            do_write(pick_addr(), 8'($urandom), 6'($urandom));
        else if (pick < 70)
            do_play(pick_addr(), pick_length(), pick_label(), 1'($urandom));
        else if (pick < 80)
            do_label_op(ACT_STOP, pick_label());
        else if (pick < 93)
            do_label_op(ACT_QUERY, pick_label());
        else
            send_item(random_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))));
    endtask

    initial begin
        bit phase_enable [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        tx_calm   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Play while disabled is refused
        do_play(14'd100, 15'd4, 16'h0001, 1'b0);
        drain();
        write_enable(1'b1);

        // Write extremes: full-scale products, floor of small negatives, zero scale
        do_write(14'd0, 8'sd127, 6'd63);
        do_write(14'd1, -8'sd128, 6'd63);
        do_write(14'd2, -8'sd1, 6'd1);
        do_write(14'h3fff, 8'sd127, 6'd32);
        do_write(14'd3, -8'sd128, 6'd0);
        do_write(14'd5, 8'sd127, 6'd32);
        do_write(14'd6, -8'sd128, 6'd32);

        // Fill all voices: wrap past the store end, zero length, looping, long lengths
        do_play(14'h3fff, 15'd3, 16'h0000, 1'b0);
        do_play(14'd0, 15'd0, 16'hffff, 1'b1);
        do_play(14'd5, 15'd1, 16'h1234, 1'b1);
        do_play(14'd5, 15'd1, 16'h1234, 1'b0);
        do_play(14'd6, 15'd1, 16'h8000, 1'b1);
        do_play(14'd2, 15'd16384, 16'h7fff, 1'b0);
        do_play(14'd1, 15'h7fff, 16'h0001, 1'b1);
        do_play(14'd3, 15'd2, 16'h0001, 1'b0);
        // No free voice left
        do_play(14'd4, 15'd1, 16'h0002, 1'b0);

        do_label_op(ACT_QUERY, 16'h1234);
        do_label_op(ACT_QUERY, 16'h5555);
        repeat (3) do_mix();
        do_label_op(ACT_STOP, 16'h0001);
        do_label_op(ACT_STOP, 16'hffff);
        send_item(random_item(ACT_SPARE_LO));
        send_item(random_item(ACT_SPARE_HI));
        do_mix();
        do_label_op(ACT_QUERY, 16'hffff);

        // Random phases, one enable setting each; long receiver hold-off in phase 1
        for (int p = 0; p < PHASES; p++) begin
            int phase_end;
            int n;

            drain();
            write_enable(phase_enable[p]);
            if (p == PHASES - 1)
                quiet = 1'b1;
            if (p == 1)
                hold_req = 1'b1;
            // Count every transfer, store fills included, toward the phase budget
            phase_end = sb.items_seen + PHASE_ITEMS;
            n = 0;
            while (sb.items_seen < phase_end) begin
                if (n % 50 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                random_step();
                n++;
            end
        end
        drain();

        $display("Covered %0d items: %0d mixes (%0d saturated), %0d plays taken, %0d refused,",
                 sb.items_seen, sb.mixes, sb.saturations, sb.plays_taken, sb.plays_refused);
        $display("%0d label stops and queries, both enable settings, long output hold-off.",
                 sb.label_ops);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
